/* src/assert_macros.svh */
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition: label");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* src/qia_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qia_pkg;

    // raw column width: holds products up to 144 with carries of about +-50
    localparam int COL_W = 10;

    // columns normalized per pipeline stage (four per carry chain)
    localparam int COLS_PER_STAGE = 8;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2
    } kind_t;

    // carries waiting for the column two places up, one per parity chain
    typedef struct packed {
        logic [COL_W-1:0] c_even;
        logic [COL_W-1:0] c_odd;
        logic             ovf;
    } carry_t;

    function automatic logic [3:0] digit_mul(input logic [1:0] x, input logic [1:0] y);
        digit_mul = {2'b00, x} * {2'b00, y};
    endfunction

endpackage

`default_nettype wire

/* src/quater_imaginary_alu_unit.sv */
// quater-imaginary (base 2i) add / subtract / multiply unit
//
// input transaction: kind, operand_a, operand_b (16 packed 2-bit digits each),
// taken when in_valid is high and in_stall is low. output transaction:
// result_digits (2*OPERAND_DIGITS digits) and overflow, taken when out_valid is
// high and out_stall is low.
//
// pipeline: input register, column register (sums, differences or product
// columns), then one register per 8 columns of carry normalization. the carry
// into a column comes from two places below, so each stage runs two chains of
// four steps. with 16 digits that is 6 register stages.
// throughput is one transaction per cycle while out_stall stays low.
//
// out_stall against a waiting result freezes the whole pipeline in place;
// in_stall is high exactly while that result waits at the output. reset clears
// all valid flags, so no result is presented until a new transaction arrives.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quater_imaginary_alu_unit #(
    parameter int OPERAND_DIGITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result_digits,
    output logic             overflow
);

    localparam int NC   = 2 * OPERAND_DIGITS;
    localparam int NSTG = (NC + qia_pkg::COLS_PER_STAGE - 1) / qia_pkg::COLS_PER_STAGE;

    logic                            adv;
    logic [NSTG+1:0]                 vld_reg;
    logic [1:0]                      kind_reg;
    logic [31:0]                     a_reg;
    logic [31:0]                     b_reg;
    logic [NC-1:0][qia_pkg::COL_W-1:0] cols_next;
    logic [NSTG:0][NC-1:0][qia_pkg::COL_W-1:0] col_reg;
    qia_pkg::carry_t [NSTG:0]        carry_reg;
    logic [NSTG-1:0][NC-1:0][qia_pkg::COL_W-1:0] col_next;
    qia_pkg::carry_t [NSTG-1:0]      carry_next;
    logic                            hi_bits_set;

    // pipeline moves whenever the output slot is empty or being taken
    assign adv       = !vld_reg[NSTG+1] || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = vld_reg[NSTG+1];
    assign overflow  = carry_reg[NSTG].ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg     <= kind;
            a_reg        <= operand_a;
            b_reg        <= operand_b;
            col_reg[0]   <= cols_next;
            carry_reg[0] <= '0;
            col_reg[NSTG:1]   <= col_next;
            carry_reg[NSTG:1] <= carry_next;
        end
    end

    qia_columns #(
        .ND (OPERAND_DIGITS)
    ) u_columns (
        .kind      (kind_reg),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .cols      (cols_next)
    );

    for (genvar s = 0; s < NSTG; s++)
    begin : g_norm
        qia_norm #(
            .NC   (NC),
            .BASE (s * qia_pkg::COLS_PER_STAGE)
        ) u_norm (
            .col_in    (col_reg[s]),
            .carry_in  (carry_reg[s]),
            .col_out   (col_next[s]),
            .carry_out (carry_next[s])
        );
    end

    always_comb
    begin
        result_digits = '0;
        hi_bits_set   = 1'b0;
        for (int i = 0; i < NC; i++)
        begin
            result_digits[2*i +: 2] = col_reg[NSTG][i][1:0];
            hi_bits_set = hi_bits_set || (col_reg[NSTG][i][qia_pkg::COL_W-1:2] != '0);
        end
    end

    // a frozen pipeline keeps every stage's occupancy
    `ASSERT_PROP(a_freeze_holds, clk, rst_n, !adv |=> $stable(vld_reg))
    // an accepted transaction lands in the input register
    `ASSERT_PROP(a_accept_loads, clk, rst_n, (in_valid && !in_stall) |=> vld_reg[0])
    // every output column has been reduced to a single digit
    `ASSERT_NEVER(a_digits_reduced, clk, rst_n, out_valid && hi_bits_set)
    // a fresh result comes from the stage below it
    `ASSERT_PROP(a_out_source, clk, rst_n, $rose(out_valid) |-> $past(vld_reg[NSTG]))

endmodule

`default_nettype wire

/* src/qia_columns.sv */
`timescale 1ns / 1ps
`default_nettype none

module qia_columns #(
    parameter int ND = 16
) (
    input  wire logic [1:0]                          kind,
    input  wire logic [31:0]                         operand_a,
    input  wire logic [31:0]                         operand_b,
    output logic      [2*ND-1:0][qia_pkg::COL_W-1:0] cols
);

    localparam int NC = 2 * ND;

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            cols[k] = '0;
        end
        unique case (qia_pkg::kind_t'(kind))
            qia_pkg::KIND_ADD:
            begin
                for (int i = 0; i < ND; i++)
                begin
                    cols[i] = qia_pkg::COL_W'(operand_a[2*i +: 2])
                            + qia_pkg::COL_W'(operand_b[2*i +: 2]);
                end
            end
            qia_pkg::KIND_SUB:
            begin
                for (int i = 0; i < ND; i++)
                begin
                    cols[i] = qia_pkg::COL_W'(operand_a[2*i +: 2])
                            - qia_pkg::COL_W'(operand_b[2*i +: 2]);
                end
            end
            qia_pkg::KIND_MUL:
            begin
                // schoolbook columns, each a sum of at most ND 4-bit products
                for (int i = 0; i < ND; i++)
                begin
                    for (int j = 0; j < ND; j++)
                    begin
                        cols[i+j] = cols[i+j] + qia_pkg::COL_W'(
                            qia_pkg::digit_mul(operand_a[2*j +: 2], operand_b[2*i +: 2]));
                    end
                end
            end
            default:
            begin
                // unused opcode leaves all columns zero
                for (int k = 0; k < NC; k++)
                begin
                    cols[k] = '0;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/qia_norm.sv */
`timescale 1ns / 1ps
`default_nettype none

module qia_norm #(
    parameter int NC   = 32,
    parameter int BASE = 0
) (
    input  wire logic [NC-1:0][qia_pkg::COL_W-1:0] col_in,
    input  wire qia_pkg::carry_t                   carry_in,
    output logic      [NC-1:0][qia_pkg::COL_W-1:0] col_out,
    output qia_pkg::carry_t                        carry_out
);

    always_comb
    begin
        logic signed [qia_pkg::COL_W-1:0] v;
        logic signed [qia_pkg::COL_W-1:0] c;
        logic signed [qia_pkg::COL_W-1:0] pend_e;
        logic signed [qia_pkg::COL_W-1:0] pend_o;
        logic                             ovf;

        col_out = col_in;
        pend_e  = $signed(carry_in.c_even);
        pend_o  = $signed(carry_in.c_odd);
        ovf     = carry_in.ovf;
        v       = '0;
        c       = '0;
        for (int k = 0; k < qia_pkg::COLS_PER_STAGE; k++)
        begin
            if (BASE + k < NC)
            begin
                // BASE is a multiple of the stage width, so k gives the parity
                if ((k % 2) == 0)
                begin
                    v      = $signed(col_in[BASE+k]) - pend_e;
                    c      = v >>> 2;
                    pend_e = c;
                end
                else
                begin
                    v      = $signed(col_in[BASE+k]) - pend_o;
                    c      = v >>> 2;
                    pend_o = c;
                end
                col_out[BASE+k] = {{(qia_pkg::COL_W-2){1'b0}}, v[1:0]};
                if ((BASE + k + 2 >= NC) && (c != '0))
                begin
                    ovf = 1'b1;
                end
            end
        end
        carry_out.c_even = pend_e;
        carry_out.c_odd  = pend_o;
        carry_out.ovf    = ovf;
    end

endmodule

`default_nettype wire

/* tb/sv/quater_imaginary_alu_unit_test.sv */
`timescale 1ns / 1ps

localparam int OPERAND_DIGITS = 16;
localparam int RESULT_DIGITS = 2 * OPERAND_DIGITS;
// kind code the block leaves unused, answered with an all-zero result
localparam logic [1:0] KIND_UNUSED = 2'd3;

class qi_result_board;
    typedef struct {
        logic [63:0] digits;
        logic        ovf;
    } qi_result_t;

    qi_result_t expected_q[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // raw columns, then floor-carry normalization toward the column two places up
    function automatic qi_result_t compute_base2i(logic [1:0] op, logic [31:0] a,
                                                  logic [31:0] b);
        longint     col[RESULT_DIGITS];
        longint     carry;
        qi_result_t r;
        int         i;
        int         j;
        r.digits = '0;
        r.ovf = 1'b0;
        foreach (col[k])
            col[k] = 0;
        if (op == KIND_UNUSED)
            return r;
        case (op)
            qia_pkg::KIND_ADD:
                for (i = 0; i < OPERAND_DIGITS; i++)
                    col[i] = longint'(a[2*i +: 2]) + longint'(b[2*i +: 2]);
            qia_pkg::KIND_SUB:
                for (i = 0; i < OPERAND_DIGITS; i++)
                    col[i] = longint'(a[2*i +: 2]) - longint'(b[2*i +: 2]);
            qia_pkg::KIND_MUL:
                for (i = 0; i < OPERAND_DIGITS; i++)
                    for (j = 0; j < OPERAND_DIGITS; j++)
                        col[i+j] += longint'(a[2*j +: 2]) * longint'(b[2*i +: 2]);
            default: ;
        endcase
        for (i = 0; i < RESULT_DIGITS; i++)
        begin
            carry = col[i] >>> 2;
            col[i] = col[i] - 4 * carry;
            if (carry != 0)
            begin
                if (i + 2 < RESULT_DIGITS)
                    col[i+2] = col[i+2] - carry;
                else
                    r.ovf = 1'b1;
            end
            r.digits[2*i +: 2] = col[i][1:0];
        end
        return r;
    endfunction

    function void note_input(logic [1:0] op, logic [31:0] a, logic [31:0] b);
        expected_q.insert(expected_q.size(), compute_base2i(op, a, b));
    endfunction

    function void check_result(logic [63:0] digits, logic ovf);
        qi_result_t exp_r;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result transaction: digits %h overflow %b",
                     $time, digits, ovf);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        if (digits !== exp_r.digits)
        begin
            $display("%0t: result_digits mismatch: expected %h actual %h",
                     $time, exp_r.digits, digits);
            errors++;
        end
        if (ovf !== exp_r.ovf)
        begin
            $display("%0t: overflow mismatch: expected %b actual %b",
                     $time, exp_r.ovf, ovf);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module quater_imaginary_alu_unit_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_digits;
    logic        overflow;

    int send_idle_pct;
    int stall_pct;
    bit hold_off_req;
    int cycle_count;

    qi_result_board board;

    quater_imaginary_alu_unit #(
        .OPERAND_DIGITS(OPERAND_DIGITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_digits(result_digits),
        .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // input and output transactions are sampled with the values from before the edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_input(kind, operand_a, operand_b);
        if (rst_n && out_valid && !out_stall)
            board.check_result(result_digits, overflow);
    end

    // receiver: random stall, plus one long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            kind <= 2'($urandom);
            operand_a <= $urandom;
            operand_b <= $urandom;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = '1;
            2: v = $urandom & $urandom;
            3: v = $urandom | $urandom;
            4: v = $urandom << (2 * $urandom_range(15));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] random_kind();
        if ($urandom_range(19) == 0)
            return KIND_UNUSED;
        return 2'($urandom_range(2));
    endfunction

    initial
    begin
        int send_pcts[4];
        int stall_pcts[4];
        int p;
        send_pcts = '{0, 75, 0, 6};
        stall_pcts = '{0, 0, 75, 6};
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = qia_pkg::KIND_ADD;
        operand_a = '0;
        operand_b = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(qia_pkg::KIND_ADD, '0, '0);
        send_item(qia_pkg::KIND_ADD, '1, '1);
        send_item(qia_pkg::KIND_ADD, 32'hC000_0000, 32'hC000_0000);
        send_item(qia_pkg::KIND_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(qia_pkg::KIND_SUB, '0, '0);
        send_item(qia_pkg::KIND_SUB, '0, 32'h0000_0001);
        send_item(qia_pkg::KIND_SUB, '0, '1);
        send_item(qia_pkg::KIND_SUB, '1, '0);
        send_item(qia_pkg::KIND_SUB, 32'h4000_0000, 32'hC000_0000);
        send_item(qia_pkg::KIND_SUB, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(qia_pkg::KIND_MUL, '0, '1);
        send_item(qia_pkg::KIND_MUL, 32'h0000_0001, 32'h0000_0001);
        send_item(qia_pkg::KIND_MUL, 32'h0000_0003, 32'h0000_0003);
        send_item(qia_pkg::KIND_MUL, '1, '1);
        send_item(qia_pkg::KIND_MUL, 32'hC000_0000, 32'hC000_0000);
        send_item(qia_pkg::KIND_MUL, 32'h0000_0002, 32'h8000_0000);
        send_item(qia_pkg::KIND_MUL, 32'h5555_5555, 32'hFFFF_FFFF);
        send_item(KIND_UNUSED, '1, '1);
        send_item(KIND_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0);

        for (p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pcts[p];
            stall_pct = stall_pcts[p];
            // fill the pipeline against a held-off receiver
            if (p == 0)
                hold_off_req = 1'b1;
            repeat (225) send_item(random_kind(), random_operand(), random_operand());
        end
        in_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
